FILE: design/servo_link_ack_frame_checker_core_assert.svh
// Assertion macros shared by the frame checker modules.
`ifndef SERVO_LINK_ACK_FRAME_CHECKER_CORE_ASSERT_SVH
`define SERVO_LINK_ACK_FRAME_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLAFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLAFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: design/slafc_pkg.sv
// Types and constants of the servo link reply frame checker.
`default_nettype none

package slafc_pkg;

  // Request codes of the input item.
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;

  // Result kinds and frame status codes.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_TIMEOUT    = 2'd1;
  localparam logic [1:0] STS_BAD_HEADER = 2'd2;
  localparam logic [1:0] STS_BAD_CHECK  = 2'd3;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ID  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LEN  = 1'd1;

  localparam logic [7:0] RST_DEVICE_ID = 8'd1;
  localparam logic [7:0] RST_FRAME_LEN = 8'd86;

  localparam logic [7:0] HDR_SYNC_BYTE = 8'hFF;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic [1:0] frame_status;
    logic       last;
  } out_item_t;

  // Classified operation handed from front to back.
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TIMEOUT,
    OP_START
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
  } q_item_t;

  typedef struct packed {
    logic [7:0] device_id;
    logic [7:0] frame_total_length;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/slafc_front.sv
// Front end: accepts input items and classifies them into queue operations.
`default_nettype none

module slafc_front (
  input  wire                 in_valid,
  input  slafc_pkg::in_item_t in_data,
  output logic                in_stall,
  input  wire                 q_full,
  output logic                q_push,
  output slafc_pkg::q_item_t  q_wdata
);

  logic known_req;

  assign in_stall = q_full;

  // The unused request code is taken and dropped here.
  always_comb begin
    known_req       = 1'b1;
    q_wdata.rx_byte = in_data.rx_byte;
    q_wdata.op      = slafc_pkg::OP_BYTE;
    unique case (in_data.req_type)
      slafc_pkg::REQ_BYTE:    q_wdata.op = slafc_pkg::OP_BYTE;
      slafc_pkg::REQ_TIMEOUT: q_wdata.op = slafc_pkg::OP_TIMEOUT;
      slafc_pkg::REQ_START:   q_wdata.op = slafc_pkg::OP_START;
      default:                known_req  = 1'b0;
    endcase
  end

  assign q_push = in_valid && !q_full && known_req;

endmodule

`default_nettype wire

FILE: design/slafc_queue.sv
// Short register queue between the front end and the frame checker.
`default_nettype none

module slafc_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  slafc_pkg::q_item_t wdata,
  output logic               full,
  input  wire                pop,
  output logic               rvalid,
  output slafc_pkg::q_item_t rdata
);

`include "servo_link_ack_frame_checker_core_assert.svh"

  localparam int DEPTH = slafc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  slafc_pkg::q_item_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  `SLAFC_ASSERT_NOW(a_no_push_when_full, full, !push)
  `SLAFC_ASSERT_NOW(a_no_pop_when_empty, !rvalid, !pop)
  `SLAFC_ASSERT_NEXT(a_push_makes_valid, push, rvalid)

endmodule

`default_nettype wire

FILE: design/slafc_back.sv
// Back end: frame state, header and checksum checks, and the output register.
`default_nettype none

module slafc_back #(
  parameter int MAX_FRAME = 128
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  slafc_pkg::cfg_t      cfg,
  input  wire                  q_valid,
  input  slafc_pkg::q_item_t   q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  output slafc_pkg::out_item_t out_data,
  input  wire                  out_stall
);

`include "servo_link_ack_frame_checker_core_assert.svh"

  localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME - 4);

  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] length_field_r, length_field_nxt;
  logic       header_good_r, header_good_nxt;
  logic       status_good_r, status_good_nxt;
  logic [7:0] received_check_r, received_check_nxt;
  logic       done_r, done_nxt;
  logic       out_valid_r, out_valid_nxt;
  slafc_pkg::out_item_t out_item_r, out_item_nxt;

  logic [7:0] b;
  logic [7:0] pos;
  logic [7:0] total;
  logic       slot_free;
  logic       is_final;
  logic       hdr_final;
  logic [1:0] final_code;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && slot_free;
  assign b         = q_rdata.rx_byte;
  assign pos       = byte_count_r;
  // A zero total behaves like a total of one.
  assign total     = (cfg.frame_total_length == 8'd0) ? 8'd1 : cfg.frame_total_length;
  assign is_final  = ({1'b0, pos} + 9'd1) >= {1'b0, total};

  always_comb begin
    byte_count_nxt     = byte_count_r;
    running_sum_nxt    = running_sum_r;
    length_field_nxt   = length_field_r;
    header_good_nxt    = header_good_r;
    status_good_nxt    = status_good_r;
    received_check_nxt = received_check_r;
    done_nxt           = done_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_item_nxt       = out_item_r;
    hdr_final          = 1'b0;
    final_code         = slafc_pkg::STS_OK;

    // Per-position checks of the byte at hand.
    if (pos == 8'd0 || pos == 8'd1) begin
      if (b != slafc_pkg::HDR_SYNC_BYTE) header_good_nxt = 1'b0;
    end else if (pos == 8'd2) begin
      if (b != cfg.device_id) header_good_nxt = 1'b0;
    end else if (pos == 8'd3) begin
      if ({1'b0, b} > MAX_LEN) header_good_nxt = 1'b0;
      length_field_nxt = b;
    end else if (pos == 8'd4) begin
      if (b != 8'd0) status_good_nxt = 1'b0;
    end

    if (pos == 8'd2 || pos == 8'd3 ||
        (pos >= 8'd4 && {1'b0, pos} <= ({1'b0, length_field_r} + 9'd2))) begin
      running_sum_nxt = running_sum_r + b;
    end
    if (pos >= 8'd4 && {2'b0, pos} == ({2'b0, length_field_r} + 10'd3)) begin
      received_check_nxt = b;
    end

    // Header positions never received count as zero bytes.
    hdr_final = header_good_nxt;
    if (pos == 8'd0) begin
      hdr_final = 1'b0;
    end else if (pos == 8'd1 && cfg.device_id != 8'd0) begin
      hdr_final = 1'b0;
    end

    if (!hdr_final) begin
      final_code = slafc_pkg::STS_BAD_HEADER;
    end else if (!status_good_nxt || (~running_sum_nxt != received_check_nxt)) begin
      final_code = slafc_pkg::STS_BAD_CHECK;
    end

    // Byte checks only commit when a byte is actually popped; restore otherwise.
    if (!(q_pop && q_rdata.op == slafc_pkg::OP_BYTE && !done_r)) begin
      running_sum_nxt    = running_sum_r;
      length_field_nxt   = length_field_r;
      header_good_nxt    = header_good_r;
      status_good_nxt    = status_good_r;
      received_check_nxt = received_check_r;
    end

    if (q_pop) begin
      unique case (q_rdata.op)
        slafc_pkg::OP_START: begin
          byte_count_nxt     = 8'd0;
          running_sum_nxt    = 8'd0;
          length_field_nxt   = 8'd0;
          header_good_nxt    = 1'b1;
          status_good_nxt    = 1'b1;
          received_check_nxt = 8'd0;
          done_nxt           = 1'b0;
        end
        slafc_pkg::OP_TIMEOUT: begin
          if (!done_r) begin
            done_nxt                   = 1'b1;
            out_valid_nxt              = 1'b1;
            out_item_nxt.item_kind     = slafc_pkg::KIND_STATUS;
            out_item_nxt.payload_byte  = 8'd0;
            out_item_nxt.payload_index = 7'd0;
            out_item_nxt.frame_status  = slafc_pkg::STS_TIMEOUT;
            out_item_nxt.last          = 1'b1;
          end
        end
        slafc_pkg::OP_BYTE: begin
          if (!done_r) begin
            byte_count_nxt = pos + 8'd1;
            if (is_final) begin
              done_nxt                   = 1'b1;
              out_valid_nxt              = 1'b1;
              out_item_nxt.item_kind     = slafc_pkg::KIND_STATUS;
              out_item_nxt.payload_byte  = 8'd0;
              out_item_nxt.payload_index = 7'd0;
              out_item_nxt.frame_status  = final_code;
              out_item_nxt.last          = 1'b1;
            end else if (pos >= 8'd5) begin
              out_valid_nxt              = 1'b1;
              out_item_nxt.item_kind     = slafc_pkg::KIND_PAYLOAD;
              out_item_nxt.payload_byte  = b;
              out_item_nxt.payload_index = 7'(pos - 8'd5);
              out_item_nxt.frame_status  = slafc_pkg::STS_OK;
              out_item_nxt.last          = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r     <= 8'd0;
      running_sum_r    <= 8'd0;
      length_field_r   <= 8'd0;
      header_good_r    <= 1'b1;
      status_good_r    <= 1'b1;
      received_check_r <= 8'd0;
      done_r           <= 1'b1;
      out_valid_r      <= 1'b0;
    end else begin
      byte_count_r     <= byte_count_nxt;
      running_sum_r    <= running_sum_nxt;
      length_field_r   <= length_field_nxt;
      header_good_r    <= header_good_nxt;
      status_good_r    <= status_good_nxt;
      received_check_r <= received_check_nxt;
      done_r           <= done_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `SLAFC_ASSERT_NOW(a_pop_needs_free_slot, q_pop, slot_free)
  `SLAFC_ASSERT_NOW(a_status_closes_exchange,
                    out_valid_r && out_item_r.last, done_r)
  `SLAFC_ASSERT_NOW(a_payload_while_open,
                    out_valid_r && (out_item_r.item_kind == slafc_pkg::KIND_PAYLOAD),
                    !done_r && !out_item_r.last)

endmodule

`default_nettype wire

FILE: design/servo_link_ack_frame_checker_core.sv
// Top level of the servo link reply frame checker.
`default_nettype none

// Checks one reply frame from a serial servo link, one received byte per item.
// A start item opens an exchange; each byte item is checked against the header
// (two sync bytes, the configured device id, a length byte within range), the
// status byte and the inverted 8-bit checksum. Payload bytes from frame offset
// five on leave as payload items; the byte that completes the configured
// frame length, or a timeout item, produces one status item with last set.
// While the output is not stalled, the block sustains one item per clock cycle in
// both directions. An accepted item is written into a two-entry queue and passes
// from there into the checker's output register; the per-byte state update in the
// back end is the feedback loop that sets this rate. When the output is stalled
// the queue absorbs up to two items before in_stall rises.
// Configuration writes are always ready and must only be issued while the
// block is idle. There is no clearing pass after reset.
module servo_link_ack_frame_checker_core #(
  parameter int MAX_FRAME = 128
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // Input item channel.
  input  wire                                    in_valid,
  input  slafc_pkg::in_item_t                    in_data,
  output logic                                   in_stall,
  // Result item channel.
  output logic                                   out_valid,
  output slafc_pkg::out_item_t                   out_data,
  input  wire                                    out_stall,
  // Configuration write channel.
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [slafc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire [7:0]                              cfg_data
);

  slafc_pkg::cfg_t    cfg_r;
  slafc_pkg::q_item_t q_wdata;
  slafc_pkg::q_item_t q_rdata;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_valid;

  // Registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_id          <= slafc_pkg::RST_DEVICE_ID;
      cfg_r.frame_total_length <= slafc_pkg::RST_FRAME_LEN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slafc_pkg::CFG_DEVICE_ID: cfg_r.device_id          <= cfg_data;
        slafc_pkg::CFG_FRAME_LEN: cfg_r.frame_total_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front classifies each accepted item and drops unused request codes.
  slafc_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // The queue lets the front keep accepting while the output is stalled.
  slafc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // The back end holds the frame state and drives the result register.
  slafc_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire
